// ===== hw/rtl/rfag_pkg.sv =====
`timescale 1ns / 1ps

package rfag_pkg;

    // Largest crop dimension; dimension registers carry one bit more than coordinates.
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

    // Pixel format codes
    localparam logic [2:0] FMT_GREY   = 3'd0;
    localparam logic [2:0] FMT_RGB565 = 3'd1;
    localparam logic [2:0] FMT_XRGB32 = 3'd2;
    localparam logic [2:0] FMT_NV12   = 3'd3;
    localparam logic [2:0] FMT_NV16   = 3'd4;

    // Quarter-turn codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROTATION    = 3'd0,
        CFG_FLIP_H      = 3'd1,
        CFG_FLIP_V      = 3'd2,
        CFG_PIXEL_FMT   = 3'd3,
        CFG_CROP_LEFT   = 3'd4,
        CFG_CROP_TOP    = 3'd5,
        CFG_CROP_WIDTH  = 3'd6,
        CFG_CROP_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         rotation;
        logic               flip_horizontal;
        logic               flip_vertical;
        logic [2:0]         pixel_format;
        logic [COORD_W-1:0] crop_left;
        logic [COORD_W-1:0] crop_top;
        logic [DIM_W-1:0]   crop_width;
        logic [DIM_W-1:0]   crop_height;
    } t_cfg;

    // Geometry of one plane
    typedef struct packed {
        logic [DIM_W-1:0]   gw;
        logic [DIM_W-1:0]   gh;
        logic [DIM_W-1:0]   ow;
        logic [DIM_W-1:0]   oh;
        logic [DIM_W-1:0]   fw;
        logic [DIM_W-1:0]   fh;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [2:0]         bytes;
        logic               special;
    } t_grid;

    // One copy descriptor
    typedef struct packed {
        logic               active;
        logic               plane_index;
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [2:0]         sample_bytes;
        logic               last_of_plane;
        logic               last_of_frame;
    } t_desc;

    function automatic logic has_chroma(input logic [2:0] fmt);
        return (fmt == FMT_NV12) || (fmt == FMT_NV16);
    endfunction

endpackage

// ===== hw/rtl/rfag_cfg_regs.sv =====
`timescale 1ns / 1ps

module rfag_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [2:0]                  i_index,
    input  logic [rfag_pkg::DIM_W-1:0]  i_data,
    output rfag_pkg::t_cfg              o_cfg
);
    import rfag_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation        <= ROT_0;
            r_cfg.flip_horizontal <= 1'b0;
            r_cfg.flip_vertical   <= 1'b0;
            r_cfg.pixel_format    <= FMT_GREY;
            r_cfg.crop_left       <= '0;
            r_cfg.crop_top        <= '0;
            r_cfg.crop_width      <= DIM_ONE;
            r_cfg.crop_height     <= DIM_ONE;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ROTATION:    r_cfg.rotation        <= i_data[1:0];
                CFG_FLIP_H:      r_cfg.flip_horizontal <= i_data[0];
                CFG_FLIP_V:      r_cfg.flip_vertical   <= i_data[0];
                CFG_PIXEL_FMT:   r_cfg.pixel_format    <= i_data[2:0];
                CFG_CROP_LEFT:   r_cfg.crop_left       <= i_data[COORD_W-1:0];
                CFG_CROP_TOP:    r_cfg.crop_top        <= i_data[COORD_W-1:0];
                CFG_CROP_WIDTH:  r_cfg.crop_width      <= i_data;
                CFG_CROP_HEIGHT: r_cfg.crop_height     <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/rfag_grid.sv =====
`timescale 1ns / 1ps

module rfag_grid (
    input  rfag_pkg::t_cfg  i_cfg,
    input  logic            i_plane,
    output rfag_pkg::t_grid o_grid
);
    import rfag_pkg::*;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             odd;
    logic             nv12;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_ONE;
        else if (v > DIM_MAX)
            return DIM_MAX;
        else
            return v;
    endfunction

    always_comb begin
        w    = clamp_dim(i_cfg.crop_width);
        h    = clamp_dim(i_cfg.crop_height);
        odd  = i_cfg.rotation[0];
        nv12 = (i_cfg.pixel_format == FMT_NV12);

        o_grid         = '0;
        o_grid.fw      = w;
        o_grid.fh      = h;
        o_grid.special = 1'b0;
        if (!i_plane) begin
            o_grid.gw   = w;
            o_grid.gh   = h;
            o_grid.left = i_cfg.crop_left;
            o_grid.top  = i_cfg.crop_top;
            case (i_cfg.pixel_format)
                FMT_RGB565: o_grid.bytes = 3'd2;
                FMT_XRGB32: o_grid.bytes = 3'd4;
                default:    o_grid.bytes = 3'd1;
            endcase
        end else begin
            o_grid.bytes = 3'd2;
            o_grid.gw    = w >> 1;
            o_grid.gh    = nv12 ? (h >> 1) : h;
            o_grid.left  = i_cfg.crop_left >> 1;
            o_grid.top   = nv12 ? (i_cfg.crop_top >> 1) : i_cfg.crop_top;
        end
        o_grid.ow = odd ? o_grid.gh : o_grid.gw;
        o_grid.oh = odd ? o_grid.gw : o_grid.gh;

        // NV16 quarter turn: chroma walked on a half-width output, every other source row
        if (i_plane && (i_cfg.pixel_format == FMT_NV16) && odd) begin
            o_grid.special = 1'b1;
            o_grid.ow      = h >> 1;
            o_grid.oh      = w;
        end
    end

endmodule

// ===== hw/rtl/rfag_map.sv =====
`timescale 1ns / 1ps

module rfag_map (
    input  rfag_pkg::t_cfg                i_cfg,
    input  rfag_pkg::t_grid               i_grid,
    input  logic [rfag_pkg::COORD_W-1:0]  i_dx,
    input  logic [rfag_pkg::COORD_W-1:0]  i_dy,
    output logic [rfag_pkg::COORD_W-1:0]  o_sx,
    output logic [rfag_pkg::COORD_W-1:0]  o_sy
);
    import rfag_pkg::*;

    // All arithmetic is modulo 4096, matching the wrap of the coordinate fields.
    logic [COORD_W-1:0] ow;
    logic [COORD_W-1:0] oh;
    logic [COORD_W-1:0] gw;
    logic [COORD_W-1:0] gh;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;

    always_comb begin
        ow = i_grid.ow[COORD_W-1:0];
        oh = i_grid.oh[COORD_W-1:0];
        gw = i_grid.gw[COORD_W-1:0];
        gh = i_grid.gh[COORD_W-1:0];
        x  = i_cfg.flip_horizontal ? (ow - COORD_W'(1) - i_dx) : i_dx;
        y  = i_cfg.flip_vertical   ? (oh - COORD_W'(1) - i_dy) : i_dy;

        if (i_grid.special) begin
            if (i_cfg.rotation == ROT_90) begin
                sx = i_dy >> 1;
                sy = i_grid.fh[COORD_W-1:0] - COORD_W'(2) - {i_dx[COORD_W-2:0], 1'b0};
            end else begin
                sx = i_grid.fw[DIM_W-1:1] - COORD_W'(1) - (i_dy >> 1);
                sy = {i_dx[COORD_W-2:0], 1'b0};
            end
        end else begin
            case (i_cfg.rotation)
                ROT_0: begin
                    sx = x;
                    sy = y;
                end
                ROT_90: begin
                    sx = y;
                    sy = gh - COORD_W'(1) - x;
                end
                ROT_180: begin
                    sx = gw - COORD_W'(1) - x;
                    sy = gh - COORD_W'(1) - y;
                end
                default: begin
                    sx = gw - COORD_W'(1) - y;
                    sy = x;
                end
            endcase
        end
        o_sx = sx + i_grid.left;
        o_sy = sy + i_grid.top;
    end

endmodule

// ===== hw/rtl/rfag_walker.sv =====
`timescale 1ns / 1ps

module rfag_walker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_restart,
    input  rfag_pkg::t_cfg  i_cfg,
    output rfag_pkg::t_desc o_desc
);
    import rfag_pkg::*;

    logic               r_running;
    logic               r_plane;
    logic [COORD_W-1:0] r_col;
    logic [DIM_W-1:0]   r_row;   // may sit one past the last row until the plane ends

    logic               n_running;
    logic               n_plane;
    logic [COORD_W-1:0] n_col;
    logic [DIM_W-1:0]   n_row;

    t_grid              grid0;
    t_grid              grid1;
    t_grid              grid_e;

    logic               chroma;
    logic               exists1;
    logic               run_s;
    logic               plane_s;
    logic [COORD_W-1:0] col_s;
    logic [DIM_W-1:0]   row_s;
    logic               inside_s;
    logic               to_chroma;
    logic               emit;
    logic               plane_e;
    logic [COORD_W-1:0] col_e;
    logic [DIM_W-1:0]   row_e;
    logic               lp;
    logic               lf;
    logic [DIM_W-1:0]   col_inc;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;

    rfag_grid u_grid0 (
        .i_cfg   (i_cfg),
        .i_plane (1'b0),
        .o_grid  (grid0)
    );

    rfag_grid u_grid1 (
        .i_cfg   (i_cfg),
        .i_plane (1'b1),
        .o_grid  (grid1)
    );

    always_comb begin
        chroma  = has_chroma(i_cfg.pixel_format);
        exists1 = chroma && (grid1.ow != '0) && (grid1.oh != '0);

        // restart overrides the walk position
        run_s   = i_restart | r_running;
        plane_s = i_restart ? 1'b0 : r_plane;
        col_s   = i_restart ? '0 : r_col;
        row_s   = i_restart ? '0 : r_row;

        if (plane_s)
            inside_s = chroma && ({1'b0, col_s} < grid1.ow) && (row_s < grid1.oh);
        else
            inside_s = ({1'b0, col_s} < grid0.ow) && (row_s < grid0.oh);

        // position fell off plane 0: go on at the chroma origin if there is one
        to_chroma = !inside_s && !plane_s && exists1;
        emit      = run_s && (inside_s || to_chroma);
        plane_e   = to_chroma ? 1'b1 : plane_s;
        col_e     = to_chroma ? '0 : col_s;
        row_e     = to_chroma ? '0 : row_s;
        grid_e    = plane_e ? grid1 : grid0;

        lp = ({1'b0, col_e} == grid_e.ow - DIM_ONE) && (row_e == grid_e.oh - DIM_ONE);
        lf = lp && (plane_e || !exists1);

        col_inc = {1'b0, col_e} + DIM_ONE;
    end

    rfag_map u_map (
        .i_cfg  (i_cfg),
        .i_grid (grid_e),
        .i_dx   (col_e),
        .i_dy   (row_e[COORD_W-1:0]),
        .o_sx   (sx),
        .o_sy   (sy)
    );

    always_comb begin
        n_running = r_running;
        n_plane   = r_plane;
        n_col     = r_col;
        n_row     = r_row;
        if (i_step) begin
            n_plane = plane_e;
            if (!emit || lf) begin
                n_running = 1'b0;
                n_col     = col_e;
                n_row     = row_e;
            end else begin
                n_running = 1'b1;
                if (col_inc >= grid_e.ow) begin
                    n_col = '0;
                    n_row = row_e + DIM_ONE;
                end else begin
                    n_col = col_inc[COORD_W-1:0];
                    n_row = row_e;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_plane   <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_running <= n_running;
            r_plane   <= n_plane;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

    always_comb begin
        o_desc = '0;
        if (emit) begin
            o_desc.active        = 1'b1;
            o_desc.plane_index   = plane_e;
            o_desc.source_x      = sx;
            o_desc.source_y      = sy;
            o_desc.dest_x        = col_e;
            o_desc.dest_y        = row_e[COORD_W-1:0];
            o_desc.sample_bytes  = grid_e.bytes;
            o_desc.last_of_plane = lp;
            o_desc.last_of_frame = lf;
        end
    end

endmodule

// ===== hw/rtl/rotate_flip_address_generator.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------------
// in       | sink      | i_in_valid / o_in_stall  | i_restart
// out      | source    | o_out_valid / i_out_stall| o_active, o_plane_index, o_source_x/y,
//          |           |                        | o_dest_x/y, o_sample_bytes, o_last_of_*
// cfg      | sink      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One step token in, one descriptor out; a new token is taken every cycle unless o_in_stall is high.
// A token passes through the token register, then the walk/map logic into the result register.
// The walk position update is a loop through the walk registers (counter increment and grid compare).
// Synchronous active-low reset clears the walk (idle) and loads register reset values.
// A stalled result holds in the output register; the token stage fills behind it and
// stalls only when both stages are full. Config is always ready.

module rotate_flip_address_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // step tokens
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_restart,
    // descriptors
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_active,
    output logic                         o_plane_index,
    output logic [rfag_pkg::COORD_W-1:0] o_source_x,
    output logic [rfag_pkg::COORD_W-1:0] o_source_y,
    output logic [rfag_pkg::COORD_W-1:0] o_dest_x,
    output logic [rfag_pkg::COORD_W-1:0] o_dest_y,
    output logic [2:0]                   o_sample_bytes,
    output logic                         o_last_of_plane,
    output logic                         o_last_of_frame,
    // register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_index,
    input  logic [rfag_pkg::DIM_W-1:0]   i_cfg_data
);
    import rfag_pkg::*;

    t_cfg  cfg;
    t_desc desc;

    logic  r_in_valid;
    logic  r_restart;
    logic  r_out_valid;
    t_desc r_desc;

    logic  advance;   // token moves into the result register this cycle

    assign o_cfg_ready = 1'b1;

    rfag_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    rfag_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_restart (r_restart),
        .i_cfg     (cfg),
        .o_desc    (desc)
    );

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_restart <= i_restart;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_desc <= desc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_active        = r_desc.active;
    assign o_plane_index   = r_desc.plane_index;
    assign o_source_x      = r_desc.source_x;
    assign o_source_y      = r_desc.source_y;
    assign o_dest_x        = r_desc.dest_x;
    assign o_dest_y        = r_desc.dest_y;
    assign o_sample_bytes  = r_desc.sample_bytes;
    assign o_last_of_plane = r_desc.last_of_plane;
    assign o_last_of_frame = r_desc.last_of_frame;

endmodule

// ===== tb/rotate_flip_address_generator_test.sv =====
`timescale 1ns / 1ps

// Step tokens go in on one channel and copy descriptors come back on the other.
// A local walker mirrors the address generator: it tracks the register file
// and the walk position, and queues the expected descriptor for every token at
// the moment that token's transfer happens. The checker pops one expectation for
// every descriptor transfer and compares it field by field.

module rotate_flip_address_generator_test;

    import rfag_pkg::*;

    localparam int ITEMS_TOTAL   = 1800;
    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off for the pressure test
    localparam int MAX_RUN_STEPS = 150;   // cap on one frame walk in the random part

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_restart;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_active;
    logic                 o_plane_index;
    logic [COORD_W-1:0]   o_source_x;
    logic [COORD_W-1:0]   o_source_y;
    logic [COORD_W-1:0]   o_dest_x;
    logic [COORD_W-1:0]   o_dest_y;
    logic [2:0]           o_sample_bytes;
    logic                 o_last_of_plane;
    logic                 o_last_of_frame;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    rotate_flip_address_generator dut (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local walker: register copy and walk position
    // ------------------------------------------------------------------
    typedef struct {
        int unsigned gw, gh;      // source grid
        int unsigned ow, oh;      // output grid
        int unsigned fw, fh;      // full crop, used by the NV16 quarter-turn chroma map
        int unsigned left, top;
        int unsigned bytes;
        bit          special;
    } t_plane_geom;

    logic [1:0]  cfg_rotation;
    bit          cfg_flip_h;
    bit          cfg_flip_v;
    logic [2:0]  cfg_format;
    int unsigned cfg_left, cfg_top, cfg_width, cfg_height;

    int unsigned walk_col, walk_row, walk_plane;
    bit          walk_running;

    t_desc pending_descs[$];   // expected descriptors, oldest first
    int    error_count = 0;
    int    items_sent  = 0;

    // Stimulus shaping, shared with the receiver process
    bit calm     = 1'b0;   // no gaps on either side
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off

    function automatic void reset_walker();
        cfg_rotation = ROT_0;
        cfg_flip_h   = 1'b0;
        cfg_flip_v   = 1'b0;
        cfg_format   = FMT_GREY;
        cfg_left     = 0;
        cfg_top      = 0;
        cfg_width    = 1;
        cfg_height   = 1;
        walk_col     = 0;
        walk_row     = 0;
        walk_plane   = 0;
        walk_running = 1'b0;
    endfunction

    function automatic void apply_reg_write(t_cfg_idx idx, logic [DIM_W-1:0] data);
        case (idx)
            CFG_ROTATION:    cfg_rotation = data[1:0];
            CFG_FLIP_H:      cfg_flip_h = data[0];
            CFG_FLIP_V:      cfg_flip_v = data[0];
            CFG_PIXEL_FMT:   cfg_format = data[2:0];
            CFG_CROP_LEFT:   cfg_left = data[COORD_W-1:0];
            CFG_CROP_TOP:    cfg_top = data[COORD_W-1:0];
            CFG_CROP_WIDTH:  cfg_width = data;
            CFG_CROP_HEIGHT: cfg_height = data;
            default: ;
        endcase
    endfunction

    // zero reads as one, anything past the largest frame reads as the largest
    function automatic int unsigned dim_clamp(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic bit format_has_chroma();
        return (cfg_format == FMT_NV12) || (cfg_format == FMT_NV16);
    endfunction

    function automatic t_plane_geom plane_geometry(int unsigned plane);
        t_plane_geom g;
        int unsigned w, h;
        bit          odd;
        bit          nv12;
        w    = dim_clamp(cfg_width);
        h    = dim_clamp(cfg_height);
        odd  = cfg_rotation[0];
        nv12 = (cfg_format == FMT_NV12);
        g.special = 1'b0;
        g.fw = w;
        g.fh = h;
        if (plane == 0) begin
            g.gw    = w;
            g.gh    = h;
            g.left  = cfg_left;
            g.top   = cfg_top;
            g.bytes = (cfg_format == FMT_RGB565) ? 2 : (cfg_format == FMT_XRGB32) ? 4 : 1;
        end else begin
            g.bytes = 2;
            if (cfg_format == FMT_NV16 && odd) begin
                // every other source row, flips ignored
                g.special = 1'b1;
                g.gw   = w / 2;
                g.gh   = h;
                g.ow   = h / 2;
                g.oh   = w;
                g.left = cfg_left / 2;
                g.top  = cfg_top;
                return g;
            end
            g.gw   = w / 2;
            g.gh   = nv12 ? h / 2 : h;
            g.left = cfg_left / 2;
            g.top  = nv12 ? cfg_top / 2 : cfg_top;
        end
        g.ow = odd ? g.gh : g.gw;
        g.oh = odd ? g.gw : g.gh;
        return g;
    endfunction

    function automatic bit plane_exists(int unsigned plane);
        t_plane_geom g;
        if (plane == 1 && !format_has_chroma()) return 1'b0;
        g = plane_geometry(plane);
        return (g.ow != 0) && (g.oh != 0);
    endfunction

    // Step off positions that fell outside the grid: next plane or end of frame.
    function automatic void walk_settle();
        t_plane_geom g;
        while (walk_running) begin
            if (plane_exists(walk_plane)) begin
                g = plane_geometry(walk_plane);
                if (walk_col < g.ow && walk_row < g.oh) return;
            end
            if (walk_plane == 0 && format_has_chroma()) begin
                walk_plane = 1;
                walk_col   = 0;
                walk_row   = 0;
            end else begin
                walk_running = 1'b0;
            end
        end
    endfunction

    function automatic t_desc next_descriptor(bit restart);
        t_plane_geom g;
        int unsigned sx, sy, x, y;
        bit          lp, lf;
        t_desc       d;
        d = '0;
        if (restart) begin
            walk_running = 1'b1;
            walk_plane   = 0;
            walk_col     = 0;
            walk_row     = 0;
        end
        walk_settle();
        if (!walk_running) return d;   // idle answer: all zero
        g = plane_geometry(walk_plane);
        if (g.special) begin
            if (cfg_rotation == ROT_90) begin
                sx = walk_row / 2;
                sy = g.fh - 2 - walk_col * 2;
            end else begin
                sx = g.fw / 2 - 1 - walk_row / 2;
                sy = walk_col * 2;
            end
        end else begin
            x = cfg_flip_h ? g.ow - 1 - walk_col : walk_col;
            y = cfg_flip_v ? g.oh - 1 - walk_row : walk_row;
            case (cfg_rotation)
                ROT_0: begin
                    sx = x;
                    sy = y;
                end
                ROT_90: begin
                    sx = y;
                    sy = g.gh - 1 - x;
                end
                ROT_180: begin
                    sx = g.gw - 1 - x;
                    sy = g.gh - 1 - y;
                end
                default: begin
                    sx = g.gw - 1 - y;
                    sy = x;
                end
            endcase
        end
        // coordinates wrap at 4096
        sx = (sx + g.left) & 32'hFFF;
        sy = (sy + g.top) & 32'hFFF;
        lp = (walk_col == g.ow - 1) && (walk_row == g.oh - 1);
        lf = lp && (walk_plane == 1 || !plane_exists(1));

        d.active        = 1'b1;
        d.plane_index   = walk_plane[0];
        d.source_x      = sx[COORD_W-1:0];
        d.source_y      = sy[COORD_W-1:0];
        d.dest_x        = walk_col[COORD_W-1:0];
        d.dest_y        = walk_row[COORD_W-1:0];
        d.sample_bytes  = g.bytes[2:0];
        d.last_of_plane = lp;
        d.last_of_frame = lf;

        if (lf) begin
            walk_running = 1'b0;
        end else begin
            walk_col++;
            if (walk_col >= g.ow) begin
                walk_col = 0;
                walk_row++;
            end
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // fill the bits a register ignores with noise
    function automatic logic [DIM_W-1:0] with_noise(logic [DIM_W-1:0] value,
                                                    logic [DIM_W-1:0] keep);
        logic [DIM_W-1:0] noise;
        noise = DIM_W'($urandom);
        return (noise & ~keep) | (value & keep);
    endfunction

    function automatic logic [DIM_W-1:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return DIM_W'($urandom_range(0, 15));
        if (r < 85) return DIM_W'(4095 - $urandom_range(0, 7));
        return DIM_W'($urandom_range(0, 4095));
    endfunction

    // small crops keep frames short; the rest hits clamping and the largest size
    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 99) < 88) return DIM_W'($urandom_range(1, 7));
        case ($urandom_range(0, 4))
            0: return DIM_W'(0);
            1: return DIM_W'(MAX_DIM);
            2: return DIM_W'(MAX_DIM + 1);
            3: return DIM_W'(8191);
            default: return DIM_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers (all inputs change at the falling edge)
    // ------------------------------------------------------------------
    // One step token. Called at a falling edge, returns at a falling edge.
    task automatic send_step(bit restart);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_restart  = restart;
        do @(posedge i_clk); while (o_in_stall);
        pending_descs.push_back(next_descriptor(restart));
        items_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DIM_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Registers only change with nothing in flight.
    task automatic drain_pipeline();
        while (pending_descs.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial begin : receiver
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_req    = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_desc want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_descs.size() == 0) begin
                $error("descriptor transfer with nothing expected");
                error_count++;
            end else begin
                want = pending_descs.pop_front();
                check_field("active",        want.active,        o_active);
                check_field("plane_index",   want.plane_index,   o_plane_index);
                check_field("source_x",      want.source_x,      o_source_x);
                check_field("source_y",      want.source_y,      o_source_y);
                check_field("dest_x",        want.dest_x,        o_dest_x);
                check_field("dest_y",        want.dest_y,        o_dest_y);
                check_field("sample_bytes",  want.sample_bytes,  o_sample_bytes);
                check_field("last_of_plane", want.last_of_plane, o_last_of_plane);
                check_field("last_of_frame", want.last_of_frame, o_last_of_frame);
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Idle answer before any frame, then the 1x1 grey frame of the reset registers.
    task automatic test_idle_and_default_frame();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    // Zero width with an oversized height and the reverse, offsets at the top so coordinates wrap.
    task automatic test_dimension_clamp();
        drain_pipeline();
        write_reg(CFG_ROTATION, with_noise(DIM_W'(ROT_270), 13'h0003));
        write_reg(CFG_FLIP_H, with_noise(13'd1, 13'h0001));
        write_reg(CFG_FLIP_V, with_noise(13'd0, 13'h0001));
        write_reg(CFG_CROP_LEFT, with_noise(13'h0FFF, 13'h0FFF));
        write_reg(CFG_CROP_TOP, with_noise(13'h0FFF, 13'h0FFF));
        write_reg(CFG_CROP_WIDTH, 13'd0);
        write_reg(CFG_CROP_HEIGHT, 13'd8191);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        drain_pipeline();
        write_reg(CFG_ROTATION, DIM_W'(ROT_90));
        write_reg(CFG_FLIP_V, 13'd1);
        write_reg(CFG_CROP_WIDTH, DIM_W'(MAX_DIM + 1));
        write_reg(CFG_CROP_HEIGHT, 13'd0);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    // NV16 quarter turns: chroma takes every other row and ignores both flips.
    task automatic test_nv16_quarter_turn();
        drain_pipeline();
        write_reg(CFG_PIXEL_FMT, DIM_W'(FMT_NV16));
        write_reg(CFG_FLIP_H, 13'd1);
        write_reg(CFG_FLIP_V, 13'd1);
        write_reg(CFG_CROP_LEFT, 13'd5);
        write_reg(CFG_CROP_TOP, 13'd3);
        write_reg(CFG_CROP_WIDTH, 13'd2);
        write_reg(CFG_CROP_HEIGHT, 13'd2);
        // 90: four luma plus two chroma, full frame
        send_step(1'b1);
        repeat (5) send_step(1'b0);
        drain_pipeline();
        write_reg(CFG_ROTATION, DIM_W'(ROT_270));
        send_step(1'b1);
        repeat (5) send_step(1'b0);
    endtask

    // Width 1 NV12: the chroma grid is empty, last luma sample ends the frame.
    task automatic test_empty_chroma();
        drain_pipeline();
        write_reg(CFG_PIXEL_FMT, DIM_W'(FMT_NV12));
        write_reg(CFG_ROTATION, DIM_W'(ROT_0));
        write_reg(CFG_FLIP_H, 13'd0);
        write_reg(CFG_FLIP_V, 13'd0);
        write_reg(CFG_CROP_WIDTH, 13'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
    endtask

    // Unknown format walks as grey; shrinking the crop mid frame ends the walk.
    task automatic test_mid_frame_change();
        drain_pipeline();
        write_reg(CFG_PIXEL_FMT, with_noise(13'd6, 13'h0007));
        write_reg(CFG_CROP_WIDTH, 13'd3);
        write_reg(CFG_CROP_HEIGHT, 13'd2);
        send_step(1'b1);
        send_step(1'b0);
        drain_pipeline();
        write_reg(CFG_CROP_WIDTH, 13'd1);
        send_step(1'b0);
    endtask

    // Receiver holds off for a long stretch while tokens keep coming, so both
    // pipeline stages fill and the input side stalls.
    task automatic test_output_hold();
        drain_pipeline();
        write_reg(CFG_PIXEL_FMT, DIM_W'(FMT_XRGB32));
        write_reg(CFG_CROP_WIDTH, 13'd4);
        write_reg(CFG_CROP_HEIGHT, 13'd4);
        calm     = 1'b1;
        hold_req = 1'b1;
        send_step(1'b1);
        repeat (11) send_step(1'b0);
        calm = 1'b0;
    endtask

    task automatic random_config(bit all_regs);
        logic [2:0] fmt;
        int         r;
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_ROTATION, with_noise(DIM_W'($urandom_range(0, 3)), 13'h0003));
        if (all_regs || $urandom_range(0, 2) == 0)
            write_reg(CFG_FLIP_H, with_noise(DIM_W'($urandom_range(0, 1)), 13'h0001));
        if (all_regs || $urandom_range(0, 2) == 0)
            write_reg(CFG_FLIP_V, with_noise(DIM_W'($urandom_range(0, 1)), 13'h0001));
        if (all_regs || $urandom_range(0, 1)) begin
            r   = $urandom_range(0, 9);
            fmt = (r < 3) ? FMT_NV12 : (r < 6) ? FMT_NV16 : 3'($urandom_range(0, 7));
            write_reg(CFG_PIXEL_FMT, with_noise(DIM_W'(fmt), 13'h0007));
        end
        if (all_regs || $urandom_range(0, 2) == 0)
            write_reg(CFG_CROP_LEFT, with_noise(pick_offset(), 13'h0FFF));
        if (all_regs || $urandom_range(0, 2) == 0)
            write_reg(CFG_CROP_TOP, with_noise(pick_offset(), 13'h0FFF));
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_CROP_WIDTH, pick_dim());
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_CROP_HEIGHT, pick_dim());
    endtask

    // Mostly complete frame walks with random geometry; some walks continue
    // across a register change, some are plain noise with random restarts.
    task automatic test_random_frames();
        int          kind;
        int unsigned frame_len;
        bit          first;
        first = 1'b1;
        while (items_sent < ITEMS_TOTAL) begin
            drain_pipeline();
            calm = ($urandom_range(0, 4) == 0);
            random_config(first);
            first = 1'b0;
            if ($urandom_range(0, 19) == 0) hold_req = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(5, 25)) send_step(1'($urandom_range(0, 1)));
            end else if (kind == 1) begin
                repeat ($urandom_range(1, 15)) send_step(1'b0);
            end else begin
                // both planes plus a few idle answers past the end
                frame_len = dim_clamp(cfg_width) * dim_clamp(cfg_height) * 2 + 3;
                if (frame_len > MAX_RUN_STEPS) frame_len = MAX_RUN_STEPS;
                send_step(1'b1);
                repeat ($urandom_range(0, frame_len)) send_step(1'b0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin : main
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROTATION;
        i_cfg_data  = '0;
        reset_walker();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_idle_and_default_frame();
        test_dimension_clamp();
        test_nv16_quarter_turn();
        test_empty_chroma();
        test_mid_frame_change();
        test_output_hold();
        test_random_frames();

        // let the last descriptors out, then watch for strays
        while (pending_descs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
